/* src/setpoint_ramp_step_generator_macros.svh */
// ----------------------------------------------------------------------------
// setpoint ramp step generator assertion macros
// shared property forms for the concurrent checks of the ramp generator
// ----------------------------------------------------------------------------
`ifndef SETPOINT_RAMP_STEP_GENERATOR_MACROS_SVH
`define SETPOINT_RAMP_STEP_GENERATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SRSG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srsg same-cycle check failed");

// next-cycle implication, disabled while in reset
`define SRSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srsg next-cycle check failed");

`endif

/* src/srsg_pkg.sv */
// ----------------------------------------------------------------------------
// srsg_pkg
// types and constants shared by the setpoint ramp step generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srsg_pkg;

    localparam int VALUE_W = 32;
    localparam int STEP_W  = 31;
    localparam int LIMIT_W = 7;
    localparam int INDEX_W = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 1'b1;

    localparam logic [STEP_W-1:0]  MAX_STEP_RESET   = '0;
    localparam logic [LIMIT_W-1:0] STEP_LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic signed [VALUE_W-1:0] current_value;
        logic signed [VALUE_W-1:0] target_value;
    } srsg_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] step_value;
        logic [INDEX_W-1:0]        step_index;
        logic                      last;
        logic                      reached_target;
    } srsg_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN
    } srsg_state_t;

    // sequencer to datapath
    typedef struct packed {
        logic               load;
        logic               prep;
        logic               step;
        logic               last;
        logic [INDEX_W-1:0] index;
    } srsg_ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic same;
        logic land;
    } srsg_stat_t;

endpackage

/* src/srsg_step_unit.sv */
// ----------------------------------------------------------------------------
// srsg_step_unit
// shared step unit: advances the value by one bounded step toward the target
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srsg_step_unit
(
    input  logic signed [srsg_pkg::VALUE_W-1:0] cur,
    input  logic signed [srsg_pkg::VALUE_W-1:0] tgt,
    input  logic [srsg_pkg::VALUE_W-1:0]        span,
    input  logic [srsg_pkg::STEP_W-1:0]         step,
    input  logic                                up,
    output logic signed [srsg_pkg::VALUE_W-1:0] next_cur,
    output logic [srsg_pkg::VALUE_W-1:0]        next_dist,
    output logic                                land
);

    logic [srsg_pkg::VALUE_W:0]   rem;
    logic [srsg_pkg::VALUE_W-1:0] step_ext;
    logic [srsg_pkg::VALUE_W-1:0] moved;

    assign step_ext = {1'b0, step};

    // borrow or zero remainder means the target is within one step
    assign rem  = {1'b0, span} - {1'b0, step_ext};
    assign land = (step == '0) || rem[srsg_pkg::VALUE_W] ||
                  (rem[srsg_pkg::VALUE_W-1:0] == '0);

    assign moved = up ? (cur + step_ext) : (cur - step_ext);

    assign next_cur  = land ? tgt : $signed(moved);
    assign next_dist = land ? '0 : rem[srsg_pkg::VALUE_W-1:0];

endmodule

/* src/srsg_ctrl.sv */
// ----------------------------------------------------------------------------
// srsg_ctrl
// sequencer: request intake, run set-up and one step per cycle up to the limit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srsg_ctrl
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [srsg_pkg::LIMIT_W-1:0]      limit,
    input  srsg_pkg::srsg_stat_t              stat,
    output srsg_pkg::srsg_ctrl_t              ctrl,
    output logic                              busy
);

    srsg_pkg::srsg_state_t           state_reg, state_next;
    logic [srsg_pkg::LIMIT_W-1:0]    count_reg, count_next;
    logic [srsg_pkg::LIMIT_W-1:0]    lim_reg, lim_next;
    logic                            final_step;

    assign final_step = stat.land || (count_reg == (lim_reg - 1'b1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srsg_pkg::ST_IDLE;
            count_reg <= '0;
            lim_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            lim_reg   <= lim_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lim_next   = lim_reg;
        case (state_reg)
            srsg_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = srsg_pkg::ST_PREP;
                    count_next = '0;
                    lim_next   = limit;
                end
            end
            srsg_pkg::ST_PREP:
            begin
                if (stat.same || (lim_reg == '0))
                    state_next = srsg_pkg::ST_IDLE;
                else
                    state_next = srsg_pkg::ST_RUN;
            end
            srsg_pkg::ST_RUN:
            begin
                count_next = count_reg + 1'b1;
                if (final_step)
                    state_next = srsg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = srsg_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl.load  = 1'b0;
        ctrl.prep  = 1'b0;
        ctrl.step  = 1'b0;
        ctrl.last  = 1'b0;
        ctrl.index = count_reg[srsg_pkg::INDEX_W-1:0];
        busy       = 1'b1;
        case (state_reg)
            srsg_pkg::ST_IDLE:
            begin
                busy      = 1'b0;
                ctrl.load = start;
            end
            srsg_pkg::ST_PREP:
            begin
                ctrl.prep = 1'b1;
            end
            srsg_pkg::ST_RUN:
            begin
                ctrl.step = 1'b1;
                ctrl.last = final_step;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

/* src/setpoint_ramp_step_generator.sv */
// ----------------------------------------------------------------------------
// setpoint_ramp_step_generator
// ramps a setpoint toward a target in bounded steps, one step per cycle
// ----------------------------------------------------------------------------
// usage:
//   a request (current_value, target_value) is taken when start is high and
//   busy is low. results come out on result, one per cycle, each marked by
//   result_valid for exactly one cycle; the receiver cannot stall them.
//   configuration writes go through cfg_valid/cfg_ready with cfg_index
//   selecting max_step or step_limit; cfg_ready is always high, and writes
//   are expected only while the block is idle.
// timing:
//   a set-up state (ST_PREP) follows the request, then one step per cycle
//   through the shared step unit; each result is registered before the port.
//   busy stays high through the set-up state and the whole run; a run gives
//   at most step_limit results, saturated at MAX_STEPS, and a request that
//   gives none holds busy only through the set-up state.
//   the next request may be taken while the final result is on the port.
// reset:
//   rst_n clears the sequencer and the result strobe; max_step resets to 0
//   and step_limit to 64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "setpoint_ramp_step_generator_macros.svh"

module setpoint_ramp_step_generator
#(
    parameter int MAX_STEPS = 64
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  srsg_pkg::srsg_req_t                request,
    output srsg_pkg::srsg_res_t                result,
    output logic                               result_valid,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [srsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srsg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [srsg_pkg::STEP_W-1:0]          max_step_reg;
    logic [srsg_pkg::LIMIT_W-1:0]         step_limit_reg;
    logic [srsg_pkg::LIMIT_W-1:0]         limit_sat;

    logic signed [srsg_pkg::VALUE_W-1:0]  cur_reg;
    logic signed [srsg_pkg::VALUE_W-1:0]  tgt_reg;
    logic [srsg_pkg::VALUE_W-1:0]         dist_reg;
    logic [srsg_pkg::STEP_W-1:0]          step_reg;
    logic                                 up_reg;

    srsg_pkg::srsg_res_t                  result_reg;
    logic                                 result_valid_reg;

    srsg_pkg::srsg_ctrl_t                 ctrl;
    srsg_pkg::srsg_stat_t                 stat;

    logic signed [srsg_pkg::VALUE_W-1:0]  next_cur;
    logic [srsg_pkg::VALUE_W-1:0]         next_dist;
    logic                                 land;
    logic                                 go_up;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg   <= srsg_pkg::MAX_STEP_RESET;
            step_limit_reg <= srsg_pkg::STEP_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                srsg_pkg::CFG_MAX_STEP:
                    max_step_reg <= cfg_data[srsg_pkg::STEP_W-1:0];
                srsg_pkg::CFG_STEP_LIMIT:
                    step_limit_reg <= cfg_data[srsg_pkg::LIMIT_W-1:0];
                default:
                    max_step_reg <= max_step_reg;
            endcase
        end
    end

    // limit above capacity saturates
    assign limit_sat = (step_limit_reg > srsg_pkg::LIMIT_W'(MAX_STEPS)) ?
                       srsg_pkg::LIMIT_W'(MAX_STEPS) : step_limit_reg;

    srsg_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .limit (limit_sat),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    srsg_step_unit u_step
    (
        .cur       (cur_reg),
        .tgt       (tgt_reg),
        .span      (dist_reg),
        .step      (step_reg),
        .up        (up_reg),
        .next_cur  (next_cur),
        .next_dist (next_dist),
        .land      (land)
    );

    assign stat.same = (cur_reg == tgt_reg);
    assign stat.land = land;
    assign go_up     = (cur_reg < tgt_reg);

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cur_reg  <= request.current_value;
            tgt_reg  <= request.target_value;
            step_reg <= max_step_reg;
        end
        else if (ctrl.prep)
        begin
            // distance wraps into 32 unsigned bits exactly
            up_reg   <= go_up;
            dist_reg <= go_up ? (tgt_reg - cur_reg) : (cur_reg - tgt_reg);
        end
        else if (ctrl.step)
        begin
            cur_reg  <= next_cur;
            dist_reg <= next_dist;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            result_reg.step_value     <= next_cur;
            result_reg.step_index     <= ctrl.index;
            result_reg.last           <= ctrl.last;
            result_reg.reached_target <= land;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= ctrl.step;
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    `SRSG_ASSERT_IMPL(a_res_after_busy, clk, rst_n, result_valid, $past(busy))
    `SRSG_ASSERT_IMPL(a_last_frees, clk, rst_n, result_valid && result.last, !busy)
    `SRSG_ASSERT_IMPL(a_reach_is_last, clk, rst_n, result_valid && result.reached_target, result.last)
    `SRSG_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !result_valid)

endmodule
